### rtl/apvt_pkg.sv
// ----------------------------------------------------------------------------
// apvt_pkg
// Shared defaults, codes and field types for the adaptive peak/valley
// threshold block.
// ----------------------------------------------------------------------------
package apvt_pkg;

  // default field widths
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF  = 24;

  // configuration register index
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_MAX = 1'b1;

  // input action codes
  typedef enum logic [1:0] {
    ACT_SAMPLE  = 2'd0,
    ACT_REBASE  = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  // result event codes
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_VALLEY = 2'd1,
    EV_PEAK   = 2'd2,
    EV_UNUSED = 2'd3
  } event_t;

  // divider handshake between sequencer and divider
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

### rtl/adaptive_peak_valley_threshold.sv
// Sequence: a sample that records a peak or valley passes the states EVAL, START, WAIT
// (serial divider, one quotient bit per cycle), THR and OUT; a rebase or a restart passes
// EVAL, THR and OUT; a sample without an event or an unknown action passes EVAL and OUT.
// Flow: a new input transaction is taken only in IDLE, after the previous result has been
// loaded into the output register, which waits on out_tready while a result is held.
// Reset: synchronous, active low; state to IDLE, counts to 1, threshold, sums and averages to 0.
// ----------------------------------------------------------------------------
// adaptive_peak_valley_threshold
// Tracks running peaks and valleys of a signed signal, keeps cumulative peak
// and valley averages and a threshold at their floor midpoint.
// ----------------------------------------------------------------------------
module adaptive_peak_valley_threshold
  import apvt_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // input stream
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   in_tdata,  // sample
  input  logic [1:0]                in_tuser,  // action
  // result stream
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata, // threshold_out, peak_average,
                                                          // valley_average
  output logic [2:0]                out_tuser, // event_res, count_overflow
  // configuration write
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [SAMPLE_WIDTH-1:0]   cfg_data
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int CW    = COUNT_WIDTH;
  localparam int DW    = SW + CW;
  localparam int OUT_W = ((3*SW+7)/8)*8;

  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [CW-1:0]        CNT_ONE = CW'(1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_START = 6'b000100,
    S_WAIT  = 6'b001000,
    S_THR   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [SW-1:0] init_min_r, init_max_r;
  action_t              act_r;
  logic signed [SW-1:0] smp_r;

  logic signed [SW-1:0] ptrk_r, ptrk_nxt;
  logic signed [SW-1:0] vtrk_r, vtrk_nxt;
  logic signed [DW-1:0] psum_r, psum_nxt;
  logic signed [DW-1:0] vsum_r, vsum_nxt;
  logic [CW-1:0]        pcnt_r, pcnt_nxt;
  logic [CW-1:0]        vcnt_r, vcnt_nxt;
  logic signed [SW-1:0] pavg_r, pavg_nxt;
  logic signed [SW-1:0] vavg_r, vavg_nxt;
  logic signed [SW-1:0] thr_r, thr_nxt;
  logic                 ovf_r, ovf_nxt;
  event_t               ev_r, ev_nxt;
  logic                 side_peak_r, side_peak_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r, out_data_nxt;
  logic [2:0]           out_user_r, out_user_nxt;

  logic signed [SW-1:0] pt_up, vt_up;
  logic                 ev_valley, ev_peak;
  logic [CW-1:0]        cnt_inc;
  logic signed [SW:0]   mid;

  div_req_t             div_req;
  div_rsp_t             div_rsp;
  logic signed [SW-1:0] div_q;

  // shared divider
  apvt_div #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (side_peak_r ? psum_r : vsum_r),
    .divisor  (side_peak_r ? pcnt_r : vcnt_r),
    .rsp      (div_rsp),
    .quotient (div_q)
  );

  assign div_req.start = (state_r == S_START);

  // configuration registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_min_r <= '0;
      init_max_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_INITIAL_MIN: init_min_r <= cfg_data;
        CFG_INITIAL_MAX: init_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input capture
  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      act_r <= action_t'(in_tuser);
      smp_r <= in_tdata[SW-1:0];
    end
  end

  // sample evaluation terms
  assign pt_up     = (smp_r > ptrk_r) ? smp_r : ptrk_r;
  assign vt_up     = (smp_r < vtrk_r) ? smp_r : vtrk_r;
  assign ev_valley = (smp_r > thr_r) && (vt_up < thr_r);
  assign ev_peak   = !ev_valley && (smp_r < thr_r) && (pt_up > thr_r);
  assign cnt_inc   = ev_valley ? vcnt_r + 1'b1 : pcnt_r + 1'b1;
  assign mid       = {pavg_r[SW-1], pavg_r} + {vavg_r[SW-1], vavg_r};

  // sequencer and state update
  always_comb begin
    state_nxt     = state_r;
    ptrk_nxt      = ptrk_r;
    vtrk_nxt      = vtrk_r;
    psum_nxt      = psum_r;
    vsum_nxt      = vsum_r;
    pcnt_nxt      = pcnt_r;
    vcnt_nxt      = vcnt_r;
    pavg_nxt      = pavg_r;
    vavg_nxt      = vavg_r;
    thr_nxt       = thr_r;
    ovf_nxt       = ovf_r;
    ev_nxt        = ev_r;
    side_peak_nxt = side_peak_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        ev_nxt    = EV_NONE;
        state_nxt = S_OUT;
        unique case (act_r)
          ACT_SAMPLE: begin
            ptrk_nxt = pt_up;
            vtrk_nxt = vt_up;
            if (ev_valley) begin
              ev_nxt        = EV_VALLEY;
              side_peak_nxt = 1'b0;
              vtrk_nxt      = SMAX;
              state_nxt     = S_START;
              if (&vcnt_r) begin
                ovf_nxt = 1'b1;
              end else begin
                vsum_nxt = vsum_r + DW'(vt_up);
                vcnt_nxt = cnt_inc;
                if (&cnt_inc) ovf_nxt = 1'b1;
              end
            end else if (ev_peak) begin
              ev_nxt        = EV_PEAK;
              side_peak_nxt = 1'b1;
              ptrk_nxt      = SMIN;
              state_nxt     = S_START;
              if (&pcnt_r) begin
                ovf_nxt = 1'b1;
              end else begin
                psum_nxt = psum_r + DW'(pt_up);
                pcnt_nxt = cnt_inc;
                if (&cnt_inc) ovf_nxt = 1'b1;
              end
            end
          end
          ACT_REBASE: begin
            // restart from current averages
            ptrk_nxt  = vavg_r;
            vtrk_nxt  = pavg_r;
            psum_nxt  = DW'(pavg_r);
            vsum_nxt  = DW'(vavg_r);
            pcnt_nxt  = CNT_ONE;
            vcnt_nxt  = CNT_ONE;
            ovf_nxt   = 1'b0;
            state_nxt = S_THR;
          end
          ACT_RESTART: begin
            // restart from configured bounds
            ptrk_nxt  = init_min_r;
            vtrk_nxt  = init_max_r;
            psum_nxt  = DW'(init_max_r);
            vsum_nxt  = DW'(init_min_r);
            pavg_nxt  = init_max_r;
            vavg_nxt  = init_min_r;
            pcnt_nxt  = CNT_ONE;
            vcnt_nxt  = CNT_ONE;
            ovf_nxt   = 1'b0;
            state_nxt = S_THR;
          end
          default: ;
        endcase
      end
      S_START: begin
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          if (side_peak_r) pavg_nxt = div_q;
          else             vavg_nxt = div_q;
          state_nxt = S_THR;
        end
      end
      S_THR: begin
        // floor midpoint of the two averages
        thr_nxt   = mid[SW:1];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({vavg_r, pavg_r, thr_r});
          out_user_nxt  = {ovf_r, ev_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // rebase keeps the averages it restarts from
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptrk_r      <= '0;
      vtrk_r      <= '0;
      psum_r      <= '0;
      vsum_r      <= '0;
      pcnt_r      <= CNT_ONE;
      vcnt_r      <= CNT_ONE;
      pavg_r      <= '0;
      vavg_r      <= '0;
      thr_r       <= '0;
      ovf_r       <= 1'b0;
      ev_r        <= EV_NONE;
      side_peak_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptrk_r      <= ptrk_nxt;
      vtrk_r      <= vtrk_nxt;
      psum_r      <= psum_nxt;
      vsum_r      <= vsum_nxt;
      pcnt_r      <= pcnt_nxt;
      vcnt_r      <= vcnt_nxt;
      pavg_r      <= pavg_nxt;
      vavg_r      <= vavg_nxt;
      thr_r       <= thr_nxt;
      ovf_r       <= ovf_nxt;
      ev_r        <= ev_nxt;
      side_peak_r <= side_peak_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  // busy after every accepted input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted twice in a row");

  // divider finishes only while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_WAIT))
    else $error("divider done outside wait state");

  // counts never reach zero
  a_counts_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (pcnt_r != '0) && (vcnt_r != '0))
    else $error("peak or valley count is zero");

  // threshold lies between the two averages when a result is loaded
  a_thr_between: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |->
      (((thr_r >= pavg_r) || (thr_r >= vavg_r)) &&
       ((thr_r <= pavg_r) || (thr_r <= vavg_r))))
    else $error("threshold outside average range");
`endif

endmodule

### rtl/apvt_div.sv
// ----------------------------------------------------------------------------
// apvt_div
// Serial restoring divider: signed sum by unsigned nonzero count, quotient
// truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module apvt_div
  import apvt_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  div_req_t                               req,
  input  logic signed [SAMPLE_WIDTH+COUNT_WIDTH-1:0] dividend,
  input  logic [COUNT_WIDTH-1:0]                 divisor,
  output div_rsp_t                               rsp,
  output logic signed [SAMPLE_WIDTH-1:0]         quotient
);

  localparam int DW    = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int CNT_W = $clog2(DW + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DW - 1);

  logic [DW-1:0]          mag_r;
  logic [COUNT_WIDTH-1:0] rem_r;
  logic [COUNT_WIDTH-1:0] dsor_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   neg_r;
  logic                   busy_r;
  logic                   done_r;

  logic [COUNT_WIDTH:0]   rem_sh;
  logic [COUNT_WIDTH+1:0] diff;
  logic                   qbit;
  logic [SAMPLE_WIDTH-1:0] qmag;

  // one trial subtraction per cycle
  assign rem_sh = {rem_r, mag_r[DW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsor_r};
  assign qbit   = ~diff[COUNT_WIDTH+1];

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r  <= dividend[DW-1];
      mag_r  <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      rem_r  <= '0;
      dsor_r <= divisor;
    end else if (busy_r) begin
      mag_r <= {mag_r[DW-2:0], qbit};
      rem_r <= qbit ? diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
    end
  end

  // magnitude of the quotient fits the sample width
  assign qmag     = mag_r[SAMPLE_WIDTH-1:0];
  assign quotient = neg_r ? -qmag : qmag;
  assign rsp.busy = busy_r;
  assign rsp.done = done_r;

endmodule
